// ===== hdl/double_ended_queue_macros.svh =====
// ---------------------------------------------------------------------------
// double_ended_queue_macros.svh
// Assertion shorthands shared by the deque RTL.
// ---------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_QUEUE_MACROS_SVH
`define DOUBLE_ENDED_QUEUE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DEQ_ASSERT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define DEQ_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/deq_pkg.sv =====
// ---------------------------------------------------------------------------
// deq_pkg
// Shared types and codes for the double-ended queue.
// ---------------------------------------------------------------------------
package deq_pkg;

  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // Request action codes as they arrive on the port
  localparam logic [ACTION_W-1:0] ACT_PUSH_FRONT = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_PUSH_BACK  = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_POP_FRONT  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_POP_BACK   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_DISPLAY    = 3'd4;

  // Response status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  // Command queue between decode and execute
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_AW    = 1;
  localparam int CMDQ_CW    = 2;

  // Decoded operation
  typedef enum logic [2:0] {
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_DISPLAY
  } op_t;

  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  // Execute-side status seen by the top level
  typedef struct packed {
    logic full;
    logic empty;
    logic streaming;
  } bk_stat_t;

endpackage

// ===== hdl/deq_front.sv =====
// ---------------------------------------------------------------------------
// deq_front
// Request decode stage: checks the action code, drops unused codes and
// registers one decoded command for the command queue.
// ---------------------------------------------------------------------------
module deq_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic [deq_pkg::ACTION_W-1:0]        action,
  input  logic signed [deq_pkg::VALUE_W-1:0]  value,
  output logic                                cmd_valid,
  input  logic                                cmd_ready,
  output deq_pkg::cmd_t                       cmd
);
  import deq_pkg::*;

  logic known;
  op_t  op_dec;

  // Action decode; unused codes carry no command
  always_comb begin
    known  = 1'b1;
    op_dec = OP_DISPLAY;
    case (action)
      ACT_PUSH_FRONT: op_dec = OP_PUSH_FRONT;
      ACT_PUSH_BACK:  op_dec = OP_PUSH_BACK;
      ACT_POP_FRONT:  op_dec = OP_POP_FRONT;
      ACT_POP_BACK:   op_dec = OP_POP_BACK;
      ACT_DISPLAY:    op_dec = OP_DISPLAY;
      default:        known  = 1'b0;
    endcase
  end

  assign req_ready = !cmd_valid || cmd_ready;

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (req_valid && req_ready && known) begin
      cmd_valid <= 1'b1;
    end else if (cmd_ready) begin
      cmd_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (req_valid && req_ready && known) begin
      cmd.op    <= op_dec;
      cmd.value <= value;
    end
  end

endmodule

// ===== hdl/deq_cmdq.sv =====
// ---------------------------------------------------------------------------
// deq_cmdq
// Two-entry command FIFO decoupling decode from execute.
// ---------------------------------------------------------------------------
module deq_cmdq (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_valid,
  output logic          s_ready,
  input  deq_pkg::cmd_t s_cmd,
  output logic          m_valid,
  input  logic          m_ready,
  output deq_pkg::cmd_t m_cmd
);
  import deq_pkg::*;

  cmd_t               slots [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wr_ptr;
  logic [CMDQ_AW-1:0] rd_ptr;
  logic [CMDQ_CW-1:0] fill;
  logic               push;
  logic               pop;

  assign s_ready = fill != CMDQ_CW'(CMDQ_DEPTH);
  assign m_valid = fill != '0;
  assign m_cmd   = slots[rd_ptr];
  assign push    = s_valid && s_ready;
  assign pop     = m_valid && m_ready;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + CMDQ_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + CMDQ_AW'(1);
      if (push && !pop) begin
        fill <= fill + CMDQ_CW'(1);
      end else if (pop && !push) begin
        fill <= fill - CMDQ_CW'(1);
      end
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= s_cmd;
  end

endmodule

// ===== hdl/deq_back.sv =====
// ---------------------------------------------------------------------------
// deq_back
// Execute stage: owns the entry memory, front index and count, runs one
// command at a time and drives the response register. Display streams the
// stored entries through a registered memory read.
// ---------------------------------------------------------------------------
module deq_back #(
  parameter int DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cmd_valid,
  output logic                                cmd_ready,
  input  deq_pkg::cmd_t                       cmd,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic signed [deq_pkg::VALUE_W-1:0]  value_res,
  output logic [deq_pkg::STATUS_W-1:0]        status,
  output logic                                last,
  output deq_pkg::bk_stat_t                   stat
);
  import deq_pkg::*;

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = IW + 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DISP = 1'b1;

  logic signed [VALUE_W-1:0] mem [DEPTH];

  logic                      state;
  logic [IW-1:0]             front_index;
  logic [CW-1:0]             entry_count;
  logic [IW-1:0]             rd_addr;
  logic [CW-1:0]             left;
  logic                      rd_valid;
  logic                      rd_last;
  logic signed [VALUE_W-1:0] rd_data;

  logic                      full;
  logic                      empty;
  logic                      out_free;
  logic                      move;
  logic                      issue;
  logic                      take;
  logic [SW-1:0]             tail_sum;
  logic [IW-1:0]             tail_addr;
  logic [IW-1:0]             front_dec;
  logic [IW-1:0]             front_inc;
  logic [IW-1:0]             rd_addr_inc;

  logic [IW-1:0]             front_index_next;
  logic [CW-1:0]             entry_count_next;
  logic                      we;
  logic [IW-1:0]             waddr;
  logic                      ld_single;
  logic [STATUS_W-1:0]       ld_status;
  logic                      start_disp;

  assign full  = entry_count == CW'(DEPTH);
  assign empty = entry_count == '0;

  // Handshake between the read stage and the response register
  assign out_free  = !rsp_valid || rsp_ready;
  assign move      = rd_valid && out_free;
  assign issue     = (state == S_DISP) && (!rd_valid || move);
  assign cmd_ready = (state == S_IDLE) && !rd_valid && out_free;
  assign take      = cmd_valid && cmd_ready;

  // Circular index arithmetic
  assign tail_sum    = SW'(front_index) + SW'(entry_count);
  assign tail_addr   = (tail_sum >= SW'(DEPTH)) ? IW'(tail_sum - SW'(DEPTH)) : IW'(tail_sum);
  assign front_dec   = (front_index == '0) ? IW'(DEPTH - 1) : front_index - IW'(1);
  assign front_inc   = (front_index == IW'(DEPTH - 1)) ? '0 : front_index + IW'(1);
  assign rd_addr_inc = (rd_addr == IW'(DEPTH - 1)) ? '0 : rd_addr + IW'(1);

  // Command execute
  always_comb begin
    front_index_next = front_index;
    entry_count_next = entry_count;
    we               = 1'b0;
    waddr            = tail_addr;
    ld_single        = 1'b0;
    ld_status        = ST_OK;
    start_disp       = 1'b0;
    if (take) begin
      ld_single = 1'b1;
      case (cmd.op)
        OP_PUSH_FRONT: begin
          if (full) begin
            ld_status = ST_FULL;
          end else begin
            front_index_next = front_dec;
            entry_count_next = entry_count + CW'(1);
            we               = 1'b1;
            waddr            = front_dec;
          end
        end
        OP_PUSH_BACK: begin
          if (full) begin
            ld_status = ST_FULL;
          end else begin
            entry_count_next = entry_count + CW'(1);
            we               = 1'b1;
          end
        end
        OP_POP_FRONT: begin
          if (empty) begin
            ld_status = ST_EMPTY;
          end else begin
            front_index_next = front_inc;
            entry_count_next = entry_count - CW'(1);
          end
        end
        OP_POP_BACK: begin
          if (empty) begin
            ld_status = ST_EMPTY;
          end else begin
            entry_count_next = entry_count - CW'(1);
          end
        end
        OP_DISPLAY: begin
          if (empty) begin
            ld_status = ST_EMPTY;
          end else begin
            ld_single  = 1'b0;
            start_disp = 1'b1;
          end
        end
        default: ld_single = 1'b0;
      endcase
    end
  end

  // Entry memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we)    mem[waddr] <= cmd.value;
    if (issue) rd_data    <= mem[rd_addr];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      front_index <= '0;
      entry_count <= '0;
      rd_valid    <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      front_index <= front_index_next;
      entry_count <= entry_count_next;
      if (start_disp) begin
        state <= S_DISP;
      end else if (issue && left == CW'(1)) begin
        state <= S_IDLE;
      end
      if (issue) begin
        rd_valid <= 1'b1;
      end else if (move) begin
        rd_valid <= 1'b0;
      end
      if (move || ld_single) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Display walk and response payload
  always_ff @(posedge clk) begin
    if (start_disp) begin
      rd_addr <= front_index;
      left    <= entry_count;
    end else if (issue) begin
      rd_addr <= rd_addr_inc;
      left    <= left - CW'(1);
    end
    if (issue) rd_last <= left == CW'(1);
    if (move) begin
      value_res <= rd_data;
      status    <= ST_OK;
      last      <= rd_last;
    end else if (ld_single) begin
      value_res <= '0;
      status    <= ld_status;
      last      <= 1'b1;
    end
  end

  assign stat.full      = full;
  assign stat.empty     = empty;
  assign stat.streaming = (state == S_DISP) || rd_valid;

endmodule

// ===== hdl/double_ended_queue.sv =====
// ---------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values held in a circular buffer.
// ---------------------------------------------------------------------------
// Each request beat carries an action: push front, push back, pop front,
// pop back or display. Pushes and pops give one response beat each (status
// ok, full or empty, value_res zero, last set). Display gives one beat per
// stored entry from front to back with last on the final one, or a single
// empty beat when nothing is stored. Action codes 5 to 7 are accepted and
// give no response. A request passes a decode register and a two-entry
// command queue before the execute stage loads its first response beat
// into the output register. The execute stage takes one command per cycle
// for push and pop while the output register is free; a display holds it
// while it starts the walk, reads each stored entry through the single
// registered read port of the entry memory, and moves the last entry into
// the output register. Responses wait in an output register without
// blocking the request side until the command queue fills.
module double_ended_queue #(
  parameter int DEPTH = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                req_valid,
  output logic                                req_ready,
  input  logic [deq_pkg::ACTION_W-1:0]        action,
  input  logic signed [deq_pkg::VALUE_W-1:0]  value,
  output logic                                rsp_valid,
  input  logic                                rsp_ready,
  output logic signed [deq_pkg::VALUE_W-1:0]  value_res,
  output logic [deq_pkg::STATUS_W-1:0]        status,
  output logic                                last
);
  import deq_pkg::*;

`include "double_ended_queue_macros.svh"

  logic      f_valid;
  logic      f_ready;
  cmd_t      f_cmd;
  logic      q_valid;
  logic      q_ready;
  cmd_t      q_cmd;
  bk_stat_t  stat;

  // Decode
  deq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .action    (action),
    .value     (value),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  // Command queue
  deq_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .s_valid (f_valid),
    .s_ready (f_ready),
    .s_cmd   (f_cmd),
    .m_valid (q_valid),
    .m_ready (q_ready),
    .m_cmd   (q_cmd)
  );

  // Execute
  deq_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .value_res (value_res),
    .status    (status),
    .last      (last),
    .stat      (stat)
  );

  // Checks
  `DEQ_ASSERT(a_full_status, clk, rst, rsp_valid && status == ST_FULL, stat.full, "full status while not full")
  `DEQ_ASSERT(a_empty_status, clk, rst, rsp_valid && status == ST_EMPTY, stat.empty, "empty status while not empty")
  `DEQ_ASSERT(a_run_open, clk, rst, rsp_valid && !last, stat.streaming, "non-final beat outside display")
  `DEQ_ASSERT_NEXT(a_run_cont, clk, rst, rsp_valid && rsp_ready && !last, rsp_valid, "display run broken")

endmodule
